FILE: hdl/line_rasterizer_defines.svh
// Assertion macros shared by the line rasterizer RTL.
// No dependencies; included by modules that carry assertions.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_rasterizer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_rasterizer: next-cycle check failed");

`endif

FILE: hdl/lr_pkg.sv
// Package for the line rasterizer: widths, opcodes and bus-width helpers.
// No dependencies.
`default_nettype none

package lr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int RGB_BITS       = 24;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Command beat: opcode, four endpoints, two deltas, two signs, error seed, color.
    function automatic int cmd_bits(input int cb);
        return 7 * cb + RGB_BITS + 5;
    endfunction

    // Pixel beat: x, y, color, last flag.
    function automatic int pix_bits(input int cb);
        return 2 * cb + RGB_BITS + 1;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/line_rasterizer.sv
// A beat is registered in the command queue, then its pixel in the pixel queue.
// Throughput: one input beat per cycle while full is low; every start or active step
// yields one pixel. The back end's error update and coordinate step set the rate.
// Reset (rst_n low, asynchronous): both queues empty, no line active.
// Top level of the line rasterizer: front end, command queue, back end, pixel queue.
// Depends on lr_pkg, lr_fifo, lr_front and lr_back.
`default_nettype none

module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output      logic                         full,
    input  wire logic                         opcode,
    input  wire logic [COORD_BITS-1:0]        start_x,
    input  wire logic [COORD_BITS-1:0]        start_y,
    input  wire logic [COORD_BITS-1:0]        end_x_in,
    input  wire logic [COORD_BITS-1:0]        end_y_in,
    input  wire logic [lr_pkg::RGB_BITS-1:0]  rgb_in,
    output      logic                         empty,
    input  wire logic                         pop,
    output      logic [COORD_BITS-1:0]        pix_x,
    output      logic [COORD_BITS-1:0]        pix_y,
    output      logic [lr_pkg::RGB_BITS-1:0]  pix_rgb,
    output      logic                         last_pixel
);

    localparam int CMD_W = lr_pkg::cmd_bits(COORD_BITS);
    localparam int PIX_W = lr_pkg::pix_bits(COORD_BITS);

    logic [CMD_W-1:0] cmd_in;
    logic [CMD_W-1:0] cmd_out;
    logic             cmd_empty;
    logic             cmd_pop;
    logic [PIX_W-1:0] pix_in;
    logic [PIX_W-1:0] pix_out;
    logic             pix_full;
    logic             pix_push;

    lr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .opcode   (opcode),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x_in (end_x_in),
        .end_y_in (end_y_in),
        .rgb_in   (rgb_in),
        .cmd      (cmd_in)
    );

    lr_fifo #(
        .WIDTH (CMD_W),
        .AW    (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    lr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_full  (pix_full),
        .out_push  (pix_push),
        .pix       (pix_in)
    );

    lr_fifo #(
        .WIDTH (PIX_W),
        .AW    (1)
    ) u_pix_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (pix_push),
        .wr_data (pix_in),
        .full    (pix_full),
        .pop     (pop),
        .rd_data (pix_out),
        .empty   (empty)
    );

    assign pix_x      = pix_out[PIX_W-1 -: COORD_BITS];
    assign pix_y      = pix_out[PIX_W-1-COORD_BITS -: COORD_BITS];
    assign pix_rgb    = pix_out[lr_pkg::RGB_BITS:1];
    assign last_pixel = pix_out[0];

endmodule

`default_nettype wire

FILE: hdl/lr_fifo.sv
// Small register-based FIFO used for the command and pixel queues.
// No dependencies.
`default_nettype none

module lr_fifo #(
    parameter int WIDTH = 8,
    parameter int AW    = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output      logic             full,
    input  wire logic             pop,
    output      logic [WIDTH-1:0] rd_data,
    output      logic             empty
);

    localparam int DEPTH = 1 << AW;

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lr_front.sv
// Front end: classifies input beats and precomputes line setup for starts.
// Depends on lr_pkg.
`default_nettype none

module lr_front #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic                                   opcode,
    input  wire logic [COORD_BITS-1:0]                  start_x,
    input  wire logic [COORD_BITS-1:0]                  start_y,
    input  wire logic [COORD_BITS-1:0]                  end_x_in,
    input  wire logic [COORD_BITS-1:0]                  end_y_in,
    input  wire logic [lr_pkg::RGB_BITS-1:0]            rgb_in,
    output      logic [lr_pkg::cmd_bits(COORD_BITS)-1:0] cmd
);

    typedef struct packed {
        logic                          opcode;
        logic [COORD_BITS-1:0]         x0;
        logic [COORD_BITS-1:0]         y0;
        logic [COORD_BITS-1:0]         x1;
        logic [COORD_BITS-1:0]         y1;
        logic [COORD_BITS-1:0]         dx;
        logic [COORD_BITS-1:0]         dy;
        logic                          neg_x;
        logic                          neg_y;
        logic signed [COORD_BITS+1:0]  err0;
        logic [lr_pkg::RGB_BITS-1:0]   rgb;
    } cmd_t;

    cmd_t cmd_w;

    always_comb
    begin
        cmd_w.opcode = opcode;
        cmd_w.x0     = start_x;
        cmd_w.y0     = start_y;
        cmd_w.x1     = end_x_in;
        cmd_w.y1     = end_y_in;
        cmd_w.neg_x  = (start_x >= end_x_in);
        cmd_w.neg_y  = (start_y >= end_y_in);
        cmd_w.dx     = cmd_w.neg_x ? start_x - end_x_in : end_x_in - start_x;
        cmd_w.dy     = cmd_w.neg_y ? start_y - end_y_in : end_y_in - start_y;
        cmd_w.err0   = signed'({2'b00, cmd_w.dx}) - signed'({2'b00, cmd_w.dy});
        cmd_w.rgb    = rgb_in;
    end

    assign cmd = cmd_w;

endmodule

`default_nettype wire

FILE: hdl/lr_back.sv
// Back end: holds the running line and walks it one pixel per start beat or per step beat while a line is active.
// Depends on lr_pkg and line_rasterizer_defines.svh.
`default_nettype none
`include "line_rasterizer_defines.svh"

module lr_back #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic [lr_pkg::cmd_bits(COORD_BITS)-1:0] cmd,
    input  wire logic                                    cmd_empty,
    output      logic                                    cmd_pop,
    input  wire logic                                    out_full,
    output      logic                                    out_push,
    output      logic [lr_pkg::pix_bits(COORD_BITS)-1:0] pix
);

    localparam int C = COORD_BITS;

    typedef struct packed {
        logic                         opcode;
        logic [C-1:0]                 x0;
        logic [C-1:0]                 y0;
        logic [C-1:0]                 x1;
        logic [C-1:0]                 y1;
        logic [C-1:0]                 dx;
        logic [C-1:0]                 dy;
        logic                         neg_x;
        logic                         neg_y;
        logic signed [C+1:0]          err0;
        logic [lr_pkg::RGB_BITS-1:0]  rgb;
    } cmd_t;

    typedef struct packed {
        logic [C-1:0]                 x;
        logic [C-1:0]                 y;
        logic [lr_pkg::RGB_BITS-1:0]  rgb;
        logic                         last;
    } pix_t;

    cmd_t cmd_w;
    pix_t pix_w;

    logic                         active_reg, active_next;
    logic [C-1:0]                 cur_x_reg, cur_x_next;
    logic [C-1:0]                 cur_y_reg, cur_y_next;
    logic [C-1:0]                 goal_x_reg, goal_x_next;
    logic [C-1:0]                 goal_y_reg, goal_y_next;
    logic [C-1:0]                 delta_x_reg, delta_x_next;
    logic [C-1:0]                 delta_y_reg, delta_y_next;
    logic                         neg_x_reg, neg_x_next;
    logic                         neg_y_reg, neg_y_next;
    logic signed [C+1:0]          err_reg, err_next;
    logic [lr_pkg::RGB_BITS-1:0]  rgb_reg, rgb_next;

    logic                         is_start;
    logic                         go;
    logic                         emit;
    logic [C-1:0]                 cx, cy, gx, gy, dx, dy;
    logic                         nx, ny;
    logic signed [C+1:0]          err_src;
    logic [lr_pkg::RGB_BITS-1:0]  rgb_src;
    logic                         last;
    logic signed [C+2:0]          e2, dx_ext, dy_ext, err_ext, err_sum;
    logic                         move_x, move_y;

    assign cmd_w    = cmd;
    assign is_start = (cmd_w.opcode == lr_pkg::OP_START);
    assign go       = !cmd_empty && (!out_full || (!is_start && !active_reg));
    assign emit     = go && (is_start || active_reg);
    assign cmd_pop  = go;
    assign out_push = emit;

    always_comb
    begin
        cx      = is_start ? cmd_w.x0    : cur_x_reg;
        cy      = is_start ? cmd_w.y0    : cur_y_reg;
        gx      = is_start ? cmd_w.x1    : goal_x_reg;
        gy      = is_start ? cmd_w.y1    : goal_y_reg;
        dx      = is_start ? cmd_w.dx    : delta_x_reg;
        dy      = is_start ? cmd_w.dy    : delta_y_reg;
        nx      = is_start ? cmd_w.neg_x : neg_x_reg;
        ny      = is_start ? cmd_w.neg_y : neg_y_reg;
        err_src = is_start ? cmd_w.err0  : err_reg;
        rgb_src = is_start ? cmd_w.rgb   : rgb_reg;

        last    = (cx == gx) && (cy == gy);
        e2      = signed'({err_src, 1'b0});
        dx_ext  = signed'({3'b000, dx});
        dy_ext  = signed'({3'b000, dy});
        err_ext = signed'({err_src[C+1], err_src});
        move_x  = (e2 > -dy_ext);
        move_y  = (e2 < dx_ext);
        err_sum = err_ext - (move_x ? dy_ext : '0) + (move_y ? dx_ext : '0);

        pix_w.x    = cx;
        pix_w.y    = cy;
        pix_w.rgb  = rgb_src;
        pix_w.last = last;

        active_next  = active_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        goal_x_next  = goal_x_reg;
        goal_y_next  = goal_y_reg;
        delta_x_next = delta_x_reg;
        delta_y_next = delta_y_reg;
        neg_x_next   = neg_x_reg;
        neg_y_next   = neg_y_reg;
        err_next     = err_reg;
        rgb_next     = rgb_reg;

        if (emit)
        begin
            active_next  = !last;
            goal_x_next  = gx;
            goal_y_next  = gy;
            delta_x_next = dx;
            delta_y_next = dy;
            neg_x_next   = nx;
            neg_y_next   = ny;
            rgb_next     = rgb_src;
            cur_x_next   = cx;
            cur_y_next   = cy;
            err_next     = err_src;
            if (!last)
            begin
                err_next = err_sum[C+1:0];
                if (move_x)
                begin
                    cur_x_next = nx ? cx - C'(1) : cx + C'(1);
                end
                if (move_y)
                begin
                    cur_y_next = ny ? cy - C'(1) : cy + C'(1);
                end
            end
        end
    end

    assign pix = pix_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        goal_x_reg  <= goal_x_next;
        goal_y_reg  <= goal_y_next;
        delta_x_reg <= delta_x_next;
        delta_y_reg <= delta_y_next;
        neg_x_reg   <= neg_x_next;
        neg_y_reg   <= neg_y_next;
        err_reg     <= err_next;
        rgb_reg     <= rgb_next;
    end

    `LR_ASSERT_NOW(a_no_push_when_full, clk, rst_n, out_push, !out_full)
    `LR_ASSERT_NEXT(a_last_ends_line, clk, rst_n, emit && last, !active_reg)
    `LR_ASSERT_NEXT(a_start_opens_line, clk, rst_n, emit && is_start && !last, active_reg)
    `LR_ASSERT_NEXT(a_step_moves, clk, rst_n, emit && !last,
        (cur_x_reg != $past(cx)) || (cur_y_reg != $past(cy)))

endmodule

`default_nettype wire
